>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gca assertion failed");

// Next-cycle implication, disabled during reset
`define GCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gca assertion failed");

`endif

>>> sv/gca_pkg.sv
// Shared types, constants and codes of the greedy assignment unit.
// Depends on nothing.
`default_nettype none
package gca_pkg;
    localparam int GCA_INT_BITS       = 16;
    localparam int GCA_FRAC_BITS      = 8;
    localparam int GCA_VALUE_W        = GCA_INT_BITS + GCA_FRAC_BITS;
    localparam int GCA_TOTAL_W        = 30;
    localparam int GCA_CUST_W         = 5;
    localparam int GCA_FAC_W          = 4;
    localparam int GCA_REQ_W          = 2;
    localparam int GCA_NC_W           = 6;
    localparam int GCA_NF_W           = 5;
    localparam int GCA_CFG_IDX_W      = 2;
    localparam int GCA_CFG_DATA_W     = 6;
    localparam int GCA_MAX_CUSTOMERS  = 32;
    localparam int GCA_MAX_FACILITIES = 16;

    localparam logic [GCA_CFG_IDX_W-1:0] CFG_NUM_CUST = 2'd0;
    localparam logic [GCA_CFG_IDX_W-1:0] CFG_NUM_FAC  = 2'd1;

    typedef enum logic [GCA_REQ_W-1:0] {
        REQ_FAC  = 2'd0,
        REQ_DEM  = 2'd1,
        REQ_COST = 2'd2,
        REQ_RUN  = 2'd3
    } t_req;

    typedef struct packed {
        logic in_ready;
        logic init;
        logic scan_step;
        logic commit;
        logic open_add;
        logic out_load;
        logic inf_load;
    } t_dp_cmd;

    typedef struct packed {
        logic run_req;
        logic scan_end;
        logic found;
        logic all_placed;
        logic fac_end;
        logic cust_end;
        logic out_free;
        logic out_busy;
    } t_dp_status;
endpackage
`default_nettype wire

>>> sv/gca_in_if.sv
// Input channel: load and run words with valid/ready.
// Depends on gca_pkg.
`default_nettype none
interface gca_in_if import gca_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [GCA_REQ_W-1:0]   req_type;
    logic [GCA_CUST_W-1:0]  cust_index;
    logic [GCA_FAC_W-1:0]   fac_index;
    logic [GCA_VALUE_W-1:0] value_a;
    logic [GCA_VALUE_W-1:0] value_b;
    modport source (output valid, req_type, cust_index, fac_index, value_a, value_b,
                    input ready);
    modport sink (input valid, req_type, cust_index, fac_index, value_a, value_b,
                  output ready);
endinterface
`default_nettype wire

>>> sv/gca_out_if.sv
// Result channel: one word per customer or one infeasible word, valid/ready.
// Depends on gca_pkg.
`default_nettype none
interface gca_out_if import gca_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [GCA_CUST_W-1:0]  customer;
    logic [GCA_FAC_W-1:0]   facility;
    logic [GCA_TOTAL_W-1:0] total_cost;
    logic                   infeasible;
    logic                   last;
    modport source (output valid, customer, facility, total_cost, infeasible, last,
                    input ready);
    modport sink (input valid, customer, facility, total_cost, infeasible, last,
                  output ready);
endinterface
`default_nettype wire

>>> sv/gca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module gca_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry when i_we is set, read one entry every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/gca_ctrl.sv
// Run sequencer: scan, decide, open-cost pass and result emission.
// Depends on gca_pkg; drives the datapath by command struct.
`default_nettype none
module gca_ctrl import gca_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);
    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SCAN      = 9'b000000010,
        ST_SCAN_WAIT = 9'b000000100,
        ST_DECIDE    = 9'b000001000,
        ST_OPEN_RD   = 9'b000010000,
        ST_OPEN_ADD  = 9'b000100000,
        ST_OUT_RD    = 9'b001000000,
        ST_OUT_WR    = 9'b010000000,
        ST_INF_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = !i_status.out_busy;
                if (i_status.run_req && !i_status.out_busy) begin
                    o_cmd.init = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_end) begin
                    n_state = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.found) begin
                    o_cmd.commit = 1'b1;
                    n_state = i_status.all_placed ? ST_OPEN_RD : ST_SCAN;
                end else begin
                    n_state = ST_INF_OUT;
                end
            end
            ST_INF_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.inf_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_OPEN_RD: begin
                n_state = ST_OPEN_ADD;
            end
            ST_OPEN_ADD: begin
                o_cmd.open_add = 1'b1;
                n_state = i_status.fac_end ? ST_OUT_RD : ST_OPEN_RD;
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_WR;
            end
            ST_OUT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = i_status.cust_end ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

>>> sv/gca_dp.sv
// Datapath: stores, scan compare, occupancy, totals and result register.
// Depends on gca_pkg, gca_ram, gca_in_if and gca_out_if.
`default_nettype none
module gca_dp import gca_pkg::*; #(
    parameter int MAX_C = GCA_MAX_CUSTOMERS,
    parameter int MAX_F = GCA_MAX_FACILITIES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [GCA_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GCA_CFG_DATA_W-1:0] i_cfg_wdata,
    gca_in_if.sink                         i_in,
    gca_out_if.source                      o_out,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_status                     o_status
);
    localparam int CIW  = (MAX_C > 1) ? $clog2(MAX_C) : 1;
    localparam int FIW  = (MAX_F > 1) ? $clog2(MAX_F) : 1;
    localparam int CNTW = $clog2(MAX_C + 1);
    localparam int FNTW = $clog2(MAX_F + 1);
    localparam int PD   = MAX_C * MAX_F;
    localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int VW   = GCA_VALUE_W;
    localparam int TW   = GCA_TOTAL_W;

    // Configuration registers
    logic [GCA_NC_W-1:0] r_cfg_nc;
    logic [GCA_NF_W-1:0] r_cfg_nf;
    logic [CNTW-1:0]     nc_eff;
    logic [FNTW-1:0]     nf_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nc <= GCA_NC_W'(1);
            r_cfg_nf <= GCA_NF_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_NUM_CUST) begin
                r_cfg_nc <= i_cfg_wdata[GCA_NC_W-1:0];
            end else if (i_cfg_idx == CFG_NUM_FAC) begin
                r_cfg_nf <= i_cfg_wdata[GCA_NF_W-1:0];
            end
        end
    end

    // Clamp counts: zero acts as one, excess acts as the maximum
    always_comb begin
        if (r_cfg_nc == '0) begin
            nc_eff = CNTW'(1);
        end else if (32'(r_cfg_nc) > MAX_C) begin
            nc_eff = CNTW'(MAX_C);
        end else begin
            nc_eff = CNTW'(r_cfg_nc);
        end
        if (r_cfg_nf == '0) begin
            nf_eff = FNTW'(1);
        end else if (32'(r_cfg_nf) > MAX_F) begin
            nf_eff = FNTW'(MAX_F);
        end else begin
            nf_eff = FNTW'(r_cfg_nf);
        end
    end

    // Load decode
    logic           in_acc, ld_c_ok, ld_f_ok;
    logic [CIW-1:0] ld_c;
    logic [FIW-1:0] ld_f;
    logic           we_fac, we_dem, we_cost;

    assign i_in.ready = i_cmd.in_ready;
    assign in_acc     = i_in.valid && i_cmd.in_ready;
    assign ld_c_ok    = 32'(i_in.cust_index) < MAX_C;
    assign ld_f_ok    = 32'(i_in.fac_index) < MAX_F;
    assign ld_c       = CIW'(i_in.cust_index);
    assign ld_f       = FIW'(i_in.fac_index);
    assign we_fac     = in_acc && (i_in.req_type == REQ_FAC) && ld_f_ok;
    assign we_dem     = in_acc && (i_in.req_type == REQ_DEM) && ld_c_ok;
    assign we_cost    = in_acc && (i_in.req_type == REQ_COST) && ld_c_ok && ld_f_ok;

    // Scan counters, run bookkeeping and best pair
    logic [CIW-1:0]  r_sc, r_s1_c, r_bc;
    logic [FIW-1:0]  r_sf, r_s1_f, r_bf;
    logic            r_s1_v, r_found;
    logic [VW-1:0]   r_best, r_bsum;
    logic [CNTW-1:0] r_placed;
    logic [TW-1:0]   r_total;
    logic [MAX_C-1:0] r_done;
    logic [MAX_F-1:0] r_used;

    logic [VW-1:0]   cost_q, dem_q, occ_q;
    logic [2*VW-1:0] fac_q;
    logic [FIW-1:0]  asg_q;
    logic            sc_last, sf_last;
    logic [PAW-1:0]  cost_raddr, cost_waddr;

    assign sc_last    = CNTW'(r_sc) == CNTW'(nc_eff - 1'b1);
    assign sf_last    = FNTW'(r_sf) == FNTW'(nf_eff - 1'b1);
    assign cost_raddr = PAW'(PAW'(r_sc) * PAW'(MAX_F) + PAW'(r_sf));
    assign cost_waddr = PAW'(PAW'(ld_c) * PAW'(MAX_F) + PAW'(ld_f));

    gca_ram #(.WIDTH(VW), .DEPTH(PD)) u_cost_ram (
        .i_clk(i_clk), .i_we(we_cost), .i_waddr(cost_waddr), .i_wdata(i_in.value_a),
        .i_raddr(cost_raddr), .o_rdata(cost_q)
    );
    gca_ram #(.WIDTH(VW), .DEPTH(MAX_C)) u_dem_ram (
        .i_clk(i_clk), .i_we(we_dem), .i_waddr(ld_c), .i_wdata(i_in.value_a),
        .i_raddr(r_sc), .o_rdata(dem_q)
    );
    gca_ram #(.WIDTH(2 * VW), .DEPTH(MAX_F)) u_fac_ram (
        .i_clk(i_clk), .i_we(we_fac), .i_waddr(ld_f),
        .i_wdata({i_in.value_b, i_in.value_a}), .i_raddr(r_sf), .o_rdata(fac_q)
    );
    gca_ram #(.WIDTH(VW), .DEPTH(MAX_F)) u_occ_ram (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(r_bf), .i_wdata(r_bsum),
        .i_raddr(r_sf), .o_rdata(occ_q)
    );
    gca_ram #(.WIDTH(FIW), .DEPTH(MAX_C)) u_asg_ram (
        .i_clk(i_clk), .i_we(i_cmd.commit), .i_waddr(r_bc), .i_wdata(r_bf),
        .i_raddr(r_sc), .o_rdata(asg_q)
    );

    // Pair test: row still open and facility has room; occupancy of an unused
    // facility reads as zero
    logic [VW-1:0] occ_eff;
    logic [VW:0]   pair_sum;
    logic          pair_ok, pair_better;

    assign occ_eff     = r_used[r_s1_f] ? occ_q : '0;
    assign pair_sum    = (VW+1)'(occ_eff) + (VW+1)'(dem_q);
    assign pair_ok     = !r_done[r_s1_c] && (pair_sum <= (VW+1)'(fac_q[VW-1:0]));
    assign pair_better = !r_found || (cost_q < r_best);

    // Control registers of the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc     <= '0;
            r_sf     <= '0;
            r_s1_v   <= 1'b0;
            r_found  <= 1'b0;
            r_placed <= '0;
            r_done   <= '0;
            r_used   <= '0;
        end else begin
            r_s1_v <= i_cmd.scan_step;
            if (i_cmd.init) begin
                r_sc     <= '0;
                r_sf     <= '0;
                r_found  <= 1'b0;
                r_placed <= '0;
                r_done   <= '0;
                r_used   <= '0;
            end else if (i_cmd.scan_step) begin
                if (sf_last) begin
                    r_sf <= '0;
                    r_sc <= sc_last ? '0 : r_sc + 1'b1;
                end else begin
                    r_sf <= r_sf + 1'b1;
                end
            end else if (i_cmd.open_add) begin
                r_sf <= sf_last ? '0 : r_sf + 1'b1;
            end else if (i_cmd.out_load) begin
                r_sc <= sc_last ? '0 : r_sc + 1'b1;
            end
            if (r_s1_v && pair_ok && pair_better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_found        <= 1'b0;
                r_placed       <= r_placed + 1'b1;
                r_done[r_bc]   <= 1'b1;
                r_used[r_bf]   <= r_used[r_bf] || (r_bsum != '0);
            end
        end
    end

    // Capture the best pair and accumulate the total
    always_ff @(posedge i_clk) begin
        if (r_s1_v && pair_ok && pair_better) begin
            r_best <= cost_q;
            r_bc   <= r_s1_c;
            r_bf   <= r_s1_f;
            r_bsum <= pair_sum[VW-1:0];
        end
        r_s1_c <= r_sc;
        r_s1_f <= r_sf;
        if (i_cmd.init) begin
            r_total <= '0;
        end else if (i_cmd.commit) begin
            r_total <= TW'(r_total + TW'(r_best));
        end else if (i_cmd.open_add && r_used[r_sf]) begin
            r_total <= TW'(r_total + TW'(fac_q[2*VW-1:VW]));
        end
    end

    // Result register
    logic                   r_out_valid, r_out_inf, r_out_last;
    logic [GCA_CUST_W-1:0]  r_out_cust;
    logic [GCA_FAC_W-1:0]   r_out_fac;
    logic [TW-1:0]          r_out_total;
    logic                   out_free;

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.inf_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cust  <= GCA_CUST_W'(r_sc);
            r_out_fac   <= GCA_FAC_W'(asg_q);
            r_out_total <= sc_last ? r_total : '0;
            r_out_inf   <= 1'b0;
            r_out_last  <= sc_last;
        end else if (i_cmd.inf_load) begin
            r_out_cust  <= '0;
            r_out_fac   <= '0;
            r_out_total <= '0;
            r_out_inf   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.customer   = r_out_cust;
    assign o_out.facility   = r_out_fac;
    assign o_out.total_cost = r_out_total;
    assign o_out.infeasible = r_out_inf;
    assign o_out.last       = r_out_last;

    // Status to the sequencer
    always_comb begin
        o_status            = '0;
        o_status.run_req    = i_in.valid && (i_in.req_type == REQ_RUN);
        o_status.scan_end   = sc_last && sf_last;
        o_status.found      = r_found;
        o_status.all_placed = CNTW'(r_placed + 1'b1) == nc_eff;
        o_status.fac_end    = sf_last;
        o_status.cust_end   = sc_last;
        o_status.out_free   = out_free;
        o_status.out_busy   = r_out_valid;
    end
endmodule
`default_nettype wire

>>> sv/greedy_capacitated_assignment_unit.sv
// Top level of the greedy capacitated assignment unit.
// Depends on gca_pkg, gca_in_if, gca_out_if, gca_ctrl and gca_dp.
//
// Usage:
//   i_in carries load words (facility record, customer demand, cost entry) and
//   run words. A load word gives no result; loads are accepted one per
//   cycle while no run is active.
//   A run word starts the greedy placement. Each placement step scans all
//   active pairs through the cost memory port; there are NC steps.
//   An open-cost pass over the NF facilities follows, then NC results on
//   o_out in customer order, total cost on the word with last set.
//   If no pair fits while a customer is unplaced, the run ends with a single
//   infeasible word.
//   The result register holds a word while o_out.ready is low; the run waits.
//   i_in.ready is low from a run word until its last result is taken.
//   Configuration writes (i_cfg_we) must come while idle; the block does not
//   enforce it. Writes are taken one per cycle. Reset sets both counts to one
//   and empties the result register; stores hold their contents until written.
`default_nettype none
module greedy_capacitated_assignment_unit import gca_pkg::*; #(
    parameter int MAX_CUSTOMERS  = GCA_MAX_CUSTOMERS,
    parameter int MAX_FACILITIES = GCA_MAX_FACILITIES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [GCA_CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GCA_CFG_DATA_W-1:0] i_cfg_wdata,
    gca_in_if.sink                         i_in,
    gca_out_if.source                      o_out
);
    t_dp_cmd    cmd;
    t_dp_status status;

    gca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_status(status), .o_cmd(cmd)
    );

    gca_dp #(.MAX_C(MAX_CUSTOMERS), .MAX_F(MAX_FACILITIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_in(i_in), .o_out(o_out), .i_cmd(cmd),
        .o_status(status)
    );
endmodule
`default_nettype wire

>>> sv/gca_checker.sv
// Port-level checks of the assignment unit, bound to its top level.
// Depends on gca_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module gca_checker import gca_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [GCA_TOTAL_W-1:0] i_out_total,
    input wire logic                   i_out_inf,
    input wire logic                   i_out_last
);
    // Stalled word stays valid with the same total, last and infeasible flags
    `GCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_total) && $stable(i_out_last) && $stable(i_out_inf))
    // No new word taken while a result waits
    `GCA_ASSERT_NOW(a_in_blocked, i_clk, i_rst_n, i_in_ready, !i_out_valid)
    // Infeasible word closes the run and carries a zero total
    `GCA_ASSERT_NOW(a_inf_last, i_clk, i_rst_n, i_out_valid && i_out_inf, i_out_last && (i_out_total == '0))
    // Total appears only on the last word
    `GCA_ASSERT_NOW(a_total_last, i_clk, i_rst_n, i_out_valid && !i_out_last, i_out_total == '0)
endmodule

bind greedy_capacitated_assignment_unit gca_checker u_gca_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_total(o_out.total_cost), .i_out_inf(o_out.infeasible),
    .i_out_last(o_out.last)
);
`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the greedy capacitated assignment unit: loads stores, starts runs,
// and checks every result word against an in-bench greedy predictor.
// Depends on gca_pkg, gca_in_if, gca_out_if and greedy_capacitated_assignment_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import gca_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [GCA_CUST_W-1:0]  customer;
        logic [GCA_FAC_W-1:0]   facility;
        logic [GCA_TOTAL_W-1:0] total_cost;
        logic                   infeasible;
        logic                   last;
    } t_result_word;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [GCA_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [GCA_CFG_DATA_W-1:0] i_cfg_wdata;

    gca_in_if  in_ch ();
    gca_out_if out_ch ();

    greedy_capacitated_assignment_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow copy of the block state
    logic [23:0] cost_shadow [GCA_MAX_CUSTOMERS][GCA_MAX_FACILITIES];
    logic [23:0] demand_shadow [GCA_MAX_CUSTOMERS];
    logic [23:0] cap_shadow [GCA_MAX_FACILITIES];
    logic [23:0] open_shadow [GCA_MAX_FACILITIES];
    logic [3:0]  placed_fac [GCA_MAX_CUSTOMERS];
    bit          cost_written [GCA_MAX_CUSTOMERS][GCA_MAX_FACILITIES];
    bit          demand_written [GCA_MAX_CUSTOMERS];
    bit          fac_written [GCA_MAX_FACILITIES];
    logic [5:0]  cust_count_reg;
    logic [4:0]  fac_count_reg;

    t_result_word expected_words [$];
    int  mismatch_count;
    int  quiet_cycles;
    bit  idle_enable;
    int  out_stall_left;
    int  out_run_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clamp_count(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 7));
            default: return 24'($urandom);
        endcase
    endfunction

    // Greedy placement over the shadow state; queue the result words
    task automatic predict_placement();
        int nc, nf, placed, bc, bf, c, f;
        bit allow [GCA_MAX_CUSTOMERS][GCA_MAX_FACILITIES];
        logic [31:0] occ [GCA_MAX_FACILITIES];
        logic [31:0] best, total;
        bit found;
        t_result_word w;
        nc = clamp_count(cust_count_reg, GCA_MAX_CUSTOMERS);
        nf = clamp_count(fac_count_reg, GCA_MAX_FACILITIES);
        for (c = 0; c < GCA_MAX_CUSTOMERS; c++)
            for (f = 0; f < GCA_MAX_FACILITIES; f++)
                allow[c][f] = (c < nc) && (f < nf);
        for (f = 0; f < GCA_MAX_FACILITIES; f++) occ[f] = 0;
        placed = 0;
        while (placed < nc) begin
            found = 0; best = 0; bc = 0; bf = 0;
            for (c = 0; c < nc; c++)
                for (f = 0; f < nf; f++)
                    if (allow[c][f] && (!found || cost_shadow[c][f] < best)) begin
                        found = 1; best = cost_shadow[c][f]; bc = c; bf = f;
                    end
            if (!found) begin
                w = '0;
                w.infeasible = 1'b1;
                w.last = 1'b1;
                expected_words.push_back(w);
                return;
            end
            if (occ[bf] + demand_shadow[bc] <= cap_shadow[bf]) begin
                for (f = 0; f < nf; f++) allow[bc][f] = 0;
                occ[bf] = (occ[bf] + demand_shadow[bc]) & 32'h1FFFFFFF;
                placed_fac[bc] = 4'(bf);
                placed++;
            end else begin
                allow[bc][bf] = 0;
            end
        end
        total = 0;
        for (f = 0; f < nf; f++)
            if (occ[f] > 0) total += open_shadow[f];
        for (c = 0; c < nc; c++) total += cost_shadow[c][placed_fac[c]];
        for (c = 0; c < nc; c++) begin
            w.customer   = 5'(c);
            w.facility   = placed_fac[c];
            w.total_cost = (c == nc - 1) ? total[29:0] : '0;
            w.infeasible = 1'b0;
            w.last       = (c == nc - 1);
            expected_words.push_back(w);
        end
    endtask

    // Update the shadow state for one accepted word; a run word queues its predicted results
    task automatic apply_word(t_req kind, logic [4:0] ci, logic [3:0] fi,
                              logic [23:0] va, logic [23:0] vb);
        case (kind)
            REQ_FAC: begin
                cap_shadow[fi] = va; open_shadow[fi] = vb; fac_written[fi] = 1;
            end
            REQ_DEM: begin
                demand_shadow[ci] = va; demand_written[ci] = 1;
            end
            REQ_COST: begin
                cost_shadow[ci][fi] = va; cost_written[ci][fi] = 1;
            end
            default: predict_placement();
        endcase
    endtask

    // Send one input word; returns at the edge that accepts it with valid held
    task automatic send_word(t_req kind, logic [4:0] ci, logic [3:0] fi,
                             logic [23:0] va, logic [23:0] vb);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= kind;
        in_ch.cust_index <= ci;
        in_ch.fac_index  <= fi;
        in_ch.value_a    <= va;
        in_ch.value_b    <= vb;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_word(kind, ci, fi, va, vb);
    endtask

    // Load any store entry the next run reads but that was never written
    task automatic fill_unwritten();
        int nc, nf, c, f;
        nc = clamp_count(cust_count_reg, GCA_MAX_CUSTOMERS);
        nf = clamp_count(fac_count_reg, GCA_MAX_FACILITIES);
        for (f = 0; f < nf; f++)
            if (!fac_written[f])
                send_word(REQ_FAC, 5'($urandom), 4'(f), 24'($urandom_range(256, 4096)),
                          pick_value());
        for (c = 0; c < nc; c++)
            if (!demand_written[c])
                send_word(REQ_DEM, 5'(c), 4'($urandom), 24'($urandom_range(0, 1024)),
                          24'($urandom));
        for (c = 0; c < nc; c++)
            for (f = 0; f < nf; f++)
                if (!cost_written[c][f])
                    send_word(REQ_COST, 5'(c), 4'(f), pick_value(), 24'($urandom));
    endtask

    task automatic start_run();
        fill_unwritten();
        send_word(REQ_RUN, 5'($urandom), 4'($urandom), 24'($urandom), 24'($urandom));
    endtask

    // Drop valid, wait for all results, then let the block settle
    task automatic drain();
        @(posedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [GCA_CFG_IDX_W-1:0] idx, logic [GCA_CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NUM_CUST: cust_count_reg = data;
            CFG_NUM_FAC:  fac_count_reg  = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_counts(int nc, int nf);
        write_reg(CFG_NUM_CUST, 6'(nc));
        write_reg(CFG_NUM_FAC, 6'(nf));
    endtask

    // Counts at reset value
    task automatic test_reset_counts();
        start_run();
        drain();
    endtask

    // Extremes, ties, rejection, zero demand, infeasible run, odd registers
    task automatic test_directed();
        set_counts(3, 2);
        send_word(REQ_FAC, 5'd0, 4'd0, 24'd512, 24'hFFFFFF);
        send_word(REQ_FAC, 5'd31, 4'd1, 24'hFFFFFF, 24'd0);
        send_word(REQ_DEM, 5'd0, 4'd0, 24'd300, 24'd0);
        send_word(REQ_DEM, 5'd1, 4'd15, 24'd300, 24'd0);
        send_word(REQ_DEM, 5'd2, 4'd0, 24'd0, 24'd0);
        send_word(REQ_COST, 5'd0, 4'd0, 24'd5, 24'd0);
        send_word(REQ_COST, 5'd0, 4'd1, 24'd5, 24'd0);
        send_word(REQ_COST, 5'd1, 4'd0, 24'd5, 24'd0);
        send_word(REQ_COST, 5'd1, 4'd1, 24'hFFFFFF, 24'd0);
        send_word(REQ_COST, 5'd2, 4'd0, 24'd0, 24'd0);
        send_word(REQ_COST, 5'd2, 4'd1, 24'd0, 24'hFFFFFF);
        start_run();
        drain();
        // No facility has room: infeasible
        send_word(REQ_FAC, 5'd0, 4'd0, 24'd0, 24'd7);
        send_word(REQ_FAC, 5'd0, 4'd1, 24'd0, 24'd7);
        send_word(REQ_DEM, 5'd2, 4'd0, 24'd1, 24'd0);
        start_run();
        drain();
        // Zero counts act as one; unused register indexes do nothing
        write_reg(CFG_NUM_CUST, 6'd0);
        write_reg(CFG_NUM_FAC, 6'd0);
        write_reg(2'd2, 6'h3F);
        write_reg(2'd3, 6'h2A);
        send_word(REQ_FAC, 5'd9, 4'd0, 24'hFFFFFF, 24'hABCDEF);
        start_run();
        drain();
    endtask

    // Random loads around random settings, each phase ending in one or two runs
    task automatic test_random_phases();
        int phase, n, k, nc, nf;
        logic [4:0] ci;
        logic [3:0] fi;
        for (phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: set_counts(0, $urandom_range(17, 31));
                1: set_counts($urandom_range(33, 63), 0);
                default: set_counts($urandom_range(1, 6), $urandom_range(1, 4));
            endcase
            if (clamp_count(cust_count_reg, 32) > 8) set_counts($urandom_range(1, 8),
                                                                  fac_count_reg);
            if (clamp_count(fac_count_reg, 16) > 4 && cust_count_reg > 4)
                set_counts(cust_count_reg, $urandom_range(1, 4));
            if (phase == 5) idle_enable = 0;
            nc = clamp_count(cust_count_reg, GCA_MAX_CUSTOMERS);
            nf = clamp_count(fac_count_reg, GCA_MAX_FACILITIES);
            n = $urandom_range(4, 10);
            for (k = 0; k < n; k++) begin
                ci = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, nc - 1));
                fi = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, nf - 1));
                case ($urandom_range(0, 2))
                    0: send_word(REQ_FAC, 5'($urandom), fi,
                                 ($urandom_range(0, 4) == 0) ? pick_value()
                                                            : 24'($urandom_range(0, 8192)),
                                 pick_value());
                    1: send_word(REQ_DEM, ci, 4'($urandom),
                                 ($urandom_range(0, 4) == 0) ? pick_value()
                                                            : 24'($urandom_range(0, 2048)),
                                 24'($urandom));
                    default: send_word(REQ_COST, ci, fi, pick_value(), 24'($urandom));
                endcase
            end
            start_run();
            if ($urandom_range(0, 2) == 0) start_run();
            drain();
        end
    endtask

    // Customer count above the maximum acts as the maximum, one run
    task automatic test_full_size();
        set_counts(63, 1);
        start_run();
        drain();
        set_counts(1, 1);
    endtask

    // Result side: random stall bursts, compare each accepted word
    always @(posedge i_clk) begin
        t_result_word got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall_left <= 0;
            out_run_left <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.customer, out_ch.facility, out_ch.total_cost,
                       out_ch.infeasible, out_ch.last};
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (out_stall_left > 0) begin
                out_stall_left <= out_stall_left - 1;
                out_ch.ready <= 1'b0;
            end else if (idle_enable && out_run_left == 0 && $urandom_range(0, 3) == 0) begin
                out_stall_left <= $urandom_range(0, 6);
                out_run_left <= $urandom_range(1, 12);
                out_ch.ready <= 1'b0;
            end else begin
                if (out_run_left > 0) out_run_left <= out_run_left - 1;
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too long with no word moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < GCA_MAX_CUSTOMERS; c++) begin
            demand_shadow[c] = '0; demand_written[c] = 0; placed_fac[c] = '0;
            for (int f = 0; f < GCA_MAX_FACILITIES; f++) begin
                cost_shadow[c][f] = '0; cost_written[c][f] = 0;
            end
        end
        for (int f = 0; f < GCA_MAX_FACILITIES; f++) begin
            cap_shadow[f] = '0; open_shadow[f] = '0; fac_written[f] = 0;
        end
        cust_count_reg = 6'd1;
        fac_count_reg  = 5'd1;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_enable    = 1;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_wdata      <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.req_type   <= '0;
        in_ch.cust_index <= '0;
        in_ch.fac_index  <= '0;
        in_ch.value_a    <= '0;
        in_ch.value_b    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_counts();
        test_directed();
        test_full_size();
        test_random_phases();

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> greedy_capacitated_assignment_unit.f
+incdir+sv
sv/gca_pkg.sv
sv/gca_in_if.sv
sv/gca_out_if.sv
sv/gca_ram.sv
sv/gca_ctrl.sv
sv/gca_dp.sv
sv/greedy_capacitated_assignment_unit.sv
sv/gca_checker.sv
verif/tb_top.sv
